FILE: rtl/arrowhead_vertex_generator_defines.svh
// Assertion macros shared by the arrowhead vertex generator RTL.
`ifndef ARROWHEAD_VERTEX_GENERATOR_DEFINES_SVH
`define ARROWHEAD_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AVG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/avg_pkg.sv
// Types, constants and register codes of the arrowhead vertex generator.
package avg_pkg;

	localparam int FRACTION_BITS_DEF = 4;

	localparam int COORD_W = 15;
	localparam int STYLE_W = 9;
	localparam int COLOR_W = 8;
	localparam int SIZE_W  = 10;
	localparam int OUT_W   = 20;
	localparam int DIFF_W  = 16;
	localparam int SQ_W    = 32;
	localparam int CONST_W = 25;
	localparam int P_W     = 41;
	localparam int MAG_W   = 40;
	localparam int ROOT_W  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int DEN_W   = 44;
	localparam int WIDE_W  = 32;
	localparam int LANES   = 4;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic signed [CONST_W-1:0] COS20_Q24 = 25'sd15765426;
	localparam logic signed [CONST_W-1:0] SIN20_Q24 = 25'sd5738146;

	localparam logic [SIZE_W-1:0] ARROW_SIZE_RST = 10'd100;

	localparam logic [1:0] REG_PER_SEG   = 2'd0;
	localparam logic [1:0] REG_COM_STYLE = 2'd1;
	localparam logic [1:0] REG_CUR_COLOR = 2'd2;
	localparam logic [1:0] REG_ARROW_SZ  = 2'd3;

	localparam int LANE_LX = 0;
	localparam int LANE_LY = 1;
	localparam int LANE_RX = 2;
	localparam int LANE_RY = 3;

	typedef struct packed {
		logic [LANES-1:0][P_W-1:0] p;
		logic [COORD_W-1:0]        ex;
		logic [COORD_W-1:0]        ey;
		logic [STYLE_W-1:0]        style;
		logic                      head;
		logic                      last;
	} avg_side_t;

	typedef struct packed {
		logic [LANES-1:0]   neg;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [STYLE_W-1:0] style;
		logic               head;
		logic               last;
	} avg_tail_t;

	typedef struct packed {
		logic adv;
		logic valid;
	} avg_ctl_t;

endpackage

FILE: rtl/avg_ifs.sv
// Segment input and arrowhead result channel interfaces.
interface avg_seg_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [avg_pkg::COORD_W-1:0]    start_x;
	logic signed [avg_pkg::COORD_W-1:0]    start_y;
	logic signed [avg_pkg::COORD_W-1:0]    end_x;
	logic signed [avg_pkg::COORD_W-1:0]    end_y;
	logic signed [avg_pkg::STYLE_W-1:0]    segment_style;
	logic                                  last_segment;

	modport source (output valid, start_x, start_y, end_x, end_y, segment_style,
		last_segment, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, segment_style,
		last_segment, output ready);
endinterface

interface avg_arrow_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [avg_pkg::STYLE_W-1:0]    line_style;
	logic                                  head_present;
	logic signed [avg_pkg::OUT_W-1:0]      left_x;
	logic signed [avg_pkg::OUT_W-1:0]      left_y;
	logic signed [avg_pkg::OUT_W-1:0]      right_x;
	logic signed [avg_pkg::OUT_W-1:0]      right_y;
	logic                                  last_arrow;

	modport source (output valid, line_style, head_present, left_x, left_y, right_x,
		right_y, last_arrow, input ready);
	modport sink (input valid, line_style, head_present, left_x, left_y, right_x,
		right_y, last_arrow, output ready);
endinterface

FILE: rtl/avg_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
module avg_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  avg_pkg::avg_ctl_t              ctl_in,
	input  logic [avg_pkg::ROOT_W-1:0]     x_in,
	input  logic [avg_pkg::ROOT_W-1:0]     r_in,
	input  avg_pkg::avg_side_t             side_in,
	output logic                           v_out,
	output logic [avg_pkg::ROOT_W-1:0]     x_out,
	output logic [avg_pkg::ROOT_W-1:0]     r_out,
	output avg_pkg::avg_side_t             side_out
);
	localparam logic [avg_pkg::ROOT_W-1:0] BIT_VAL =
		avg_pkg::ROOT_W'(1) << (avg_pkg::ROOT_W - 2 - 2 * STEP);

	logic [avg_pkg::ROOT_W-1:0] trial;
	logic                       take;
	logic                       v_q;
	logic [avg_pkg::ROOT_W-1:0] x_q;
	logic [avg_pkg::ROOT_W-1:0] r_q;
	avg_pkg::avg_side_t         side_q;

	assign trial = r_in + BIT_VAL;
	assign take  = x_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl_in.adv) begin
			v_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.adv) begin
			x_q    <= take ? (x_in - trial) : x_in;
			r_q    <= take ? ((r_in >> 1) + BIT_VAL) : (r_in >> 1);
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign x_out    = x_q;
	assign r_out    = r_q;
	assign side_out = side_q;
endmodule

FILE: rtl/avg_div_cell.sv
// One cell of the divider chain: settles one quotient bit for all four lanes.
module avg_div_cell #(
	parameter int FRACTION_BITS = avg_pkg::FRACTION_BITS_DEF,
	parameter int BIT_POS       = 0
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  avg_pkg::avg_ctl_t                                  ctl_in,
	input  logic [avg_pkg::DEN_W-1:0]                          d_in,
	input  logic [avg_pkg::LANES-1:0][53+FRACTION_BITS-1:0]    rem_in,
	input  logic [avg_pkg::LANES-1:0][8+FRACTION_BITS-1:0]     q_in,
	input  avg_pkg::avg_tail_t                                 tail_in,
	output logic                                               v_out,
	output logic [avg_pkg::DEN_W-1:0]                          d_out,
	output logic [avg_pkg::LANES-1:0][53+FRACTION_BITS-1:0]    rem_out,
	output logic [avg_pkg::LANES-1:0][8+FRACTION_BITS-1:0]     q_out,
	output avg_pkg::avg_tail_t                                 tail_out
);
	localparam int RW = 53 + FRACTION_BITS;
	localparam int QW = 8 + FRACTION_BITS;

	logic [RW-1:0]                         dsh;
	logic [avg_pkg::LANES-1:0][RW-1:0]     rem_n;
	logic [avg_pkg::LANES-1:0][QW-1:0]     q_n;
	logic                                  v_q;
	logic [avg_pkg::DEN_W-1:0]             d_q;
	logic [avg_pkg::LANES-1:0][RW-1:0]     rem_q;
	logic [avg_pkg::LANES-1:0][QW-1:0]     q_q;
	avg_pkg::avg_tail_t                    tail_q;

	assign dsh = RW'(d_in) << BIT_POS;

	always_comb begin
		for (int l = 0; l < avg_pkg::LANES; l++) begin
			q_n[l] = q_in[l];
			if (rem_in[l] >= dsh) begin
				rem_n[l]          = rem_in[l] - dsh;
				q_n[l][BIT_POS]   = 1'b1;
			end else begin
				rem_n[l]          = rem_in[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl_in.adv) begin
			v_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.adv) begin
			d_q    <= d_in;
			rem_q  <= rem_n;
			q_q    <= q_n;
			tail_q <= tail_in;
		end
	end

	assign v_out    = v_q;
	assign d_out    = d_q;
	assign rem_out  = rem_q;
	assign q_out    = q_q;
	assign tail_out = tail_q;
endmodule

FILE: rtl/arrowhead_vertex_generator.sv
// Top level of the arrowhead vertex generator: config, front stages, cell chains, output.
//
// Channel  Dir  Handshake      Payload
// seg      in   valid/ready    start_x, start_y, end_x, end_y, segment_style, last_segment
// arrow    out  valid/ready    line_style, head_present, left/right x/y, last_arrow
// apb      in   psel/penable   paddr, pwdata, pwrite; prdata, pready
//
// One segment is taken every cycle unless the chain stalls; it passes in a row through
// 32 square root cells and then through 8 + FRACTION_BITS divider cells.
// All stages advance together; while arrow holds a result that is not taken, the whole
// chain and seg.ready hold. arst_n clears valid bits and config registers only.
`include "arrowhead_vertex_generator_defines.svh"

module arrowhead_vertex_generator #(
	parameter int FRACTION_BITS = avg_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [avg_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [avg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [avg_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	avg_seg_if.sink                            seg,
	avg_arrow_if.source                        arrow
);
	localparam int RW = 53 + FRACTION_BITS;
	localparam int QW = 8 + FRACTION_BITS;
	localparam int NS = avg_pkg::SQRT_STEPS;

	logic                            per_seg_q;
	logic [avg_pkg::STYLE_W-1:0]     com_style_q;
	logic [avg_pkg::COLOR_W-1:0]     cur_color_q;
	logic [avg_pkg::SIZE_W-1:0]      arrow_size_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_seg_q    <= 1'b0;
			com_style_q  <= '0;
			cur_color_q  <= '0;
			arrow_size_q <= avg_pkg::ARROW_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				avg_pkg::REG_PER_SEG:   per_seg_q    <= pwdata[0];
				avg_pkg::REG_COM_STYLE: com_style_q  <= pwdata[avg_pkg::STYLE_W-1:0];
				avg_pkg::REG_CUR_COLOR: cur_color_q  <= pwdata[avg_pkg::COLOR_W-1:0];
				avg_pkg::REG_ARROW_SZ:  arrow_size_q <= pwdata[avg_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			avg_pkg::REG_PER_SEG:   prdata = avg_pkg::APB_DATA_W'(per_seg_q);
			avg_pkg::REG_COM_STYLE: prdata = avg_pkg::APB_DATA_W'(com_style_q);
			avg_pkg::REG_CUR_COLOR: prdata = avg_pkg::APB_DATA_W'(cur_color_q);
			avg_pkg::REG_ARROW_SZ:  prdata = avg_pkg::APB_DATA_W'(arrow_size_q);
			default:                prdata = '0;
		endcase
	end

	// Global advance: the output register frees up or is empty.
	logic out_valid_q;
	logic adv;

	assign adv       = !out_valid_q || arrow.ready;
	assign seg.ready = adv;

	// Stage 1: differences and style choice.
	logic                               v_s1;
	logic signed [avg_pkg::DIFF_W-1:0]  dx_s1;
	logic signed [avg_pkg::DIFF_W-1:0]  dy_s1;
	logic [avg_pkg::COORD_W-1:0]        ex_s1;
	logic [avg_pkg::COORD_W-1:0]        ey_s1;
	logic [avg_pkg::STYLE_W-1:0]        style_s1;
	logic                               last_s1;
	logic [avg_pkg::STYLE_W-1:0]        style_c;

	always_comb begin
		if (per_seg_q) begin
			style_c = seg.segment_style;
		end else if ($signed(com_style_q) < $signed(avg_pkg::STYLE_W'(1))) begin
			style_c = avg_pkg::STYLE_W'(cur_color_q);
		end else begin
			style_c = com_style_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= avg_pkg::DIFF_W'(seg.end_x) - avg_pkg::DIFF_W'(seg.start_x);
			dy_s1    <= avg_pkg::DIFF_W'(seg.end_y) - avg_pkg::DIFF_W'(seg.start_y);
			ex_s1    <= seg.end_x;
			ey_s1    <= seg.end_y;
			style_s1 <= style_c;
			last_s1  <= seg.last_segment;
		end
	end

	// Stage 2: rotation products and squared length.
	logic                               v_s2;
	logic signed [avg_pkg::P_W-1:0]     cdx_s2;
	logic signed [avg_pkg::P_W-1:0]     sdy_s2;
	logic signed [avg_pkg::P_W-1:0]     sdx_s2;
	logic signed [avg_pkg::P_W-1:0]     cdy_s2;
	logic [avg_pkg::SQ_W-1:0]           sq_s2;
	logic [avg_pkg::COORD_W-1:0]        ex_s2;
	logic [avg_pkg::COORD_W-1:0]        ey_s2;
	logic [avg_pkg::STYLE_W-1:0]        style_s2;
	logic                               last_s2;
	logic signed [avg_pkg::SQ_W:0]      sq_c;

	assign sq_c = (avg_pkg::SQ_W+1)'(dx_s1) * (avg_pkg::SQ_W+1)'(dx_s1)
		+ (avg_pkg::SQ_W+1)'(dy_s1) * (avg_pkg::SQ_W+1)'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cdx_s2   <= avg_pkg::P_W'(avg_pkg::COS20_Q24) * avg_pkg::P_W'(dx_s1);
			sdy_s2   <= avg_pkg::P_W'(avg_pkg::SIN20_Q24) * avg_pkg::P_W'(dy_s1);
			sdx_s2   <= avg_pkg::P_W'(avg_pkg::SIN20_Q24) * avg_pkg::P_W'(dx_s1);
			cdy_s2   <= avg_pkg::P_W'(avg_pkg::COS20_Q24) * avg_pkg::P_W'(dy_s1);
			sq_s2    <= sq_c[avg_pkg::SQ_W-1:0];
			ex_s2    <= ex_s1;
			ey_s2    <= ey_s1;
			style_s2 <= style_s1;
			last_s2  <= last_s1;
		end
	end

	// Square root chain.
	avg_pkg::avg_side_t             side_c;
	logic                           sq_v    [0:NS];
	logic [avg_pkg::ROOT_W-1:0]     sq_x    [0:NS];
	logic [avg_pkg::ROOT_W-1:0]     sq_r    [0:NS];
	avg_pkg::avg_side_t             sq_side [0:NS];

	always_comb begin
		side_c.p[avg_pkg::LANE_LX] = cdx_s2 - sdy_s2;
		side_c.p[avg_pkg::LANE_LY] = sdx_s2 + cdy_s2;
		side_c.p[avg_pkg::LANE_RX] = cdx_s2 + sdy_s2;
		side_c.p[avg_pkg::LANE_RY] = cdy_s2 - sdx_s2;
		side_c.ex    = ex_s2;
		side_c.ey    = ey_s2;
		side_c.style = style_s2;
		side_c.head  = sq_s2 != '0;
		side_c.last  = last_s2;
	end

	assign sq_v[0]    = v_s2;
	assign sq_x[0]    = {sq_s2, avg_pkg::SQ_W'(0)};
	assign sq_r[0]    = '0;
	assign sq_side[0] = side_c;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		avg_pkg::avg_ctl_t ctl;
		assign ctl.adv   = adv;
		assign ctl.valid = sq_v[k];
		avg_sqrt_cell #(.STEP(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl),
			.x_in     (sq_x[k]),
			.r_in     (sq_r[k]),
			.side_in  (sq_side[k]),
			.v_out    (sq_v[k+1]),
			.x_out    (sq_x[k+1]),
			.r_out    (sq_r[k+1]),
			.side_out (sq_side[k+1])
		);
	end

	// Stage 4: dividend and divisor per lane.
	logic [avg_pkg::SQ_W-1:0]                 root_c;
	logic [avg_pkg::DEN_W-2:0]                den_c;
	logic [avg_pkg::LANES-1:0][RW-1:0]        n_c;
	logic [avg_pkg::LANES-1:0]                neg_c;
	logic [avg_pkg::LANES-1:0][avg_pkg::P_W-1:0] absp_c;
	avg_pkg::avg_tail_t                       tail_c;
	logic                                     v_s4;
	logic [avg_pkg::DEN_W-1:0]                d_s4;
	logic [avg_pkg::LANES-1:0][RW-1:0]        n_s4;
	avg_pkg::avg_tail_t                       tail_s4;

	assign root_c = sq_r[NS][avg_pkg::SQ_W-1:0];
	assign den_c  = ((avg_pkg::DEN_W-1)'(root_c) << 11) + ((avg_pkg::DEN_W-1)'(root_c) << 9);

	always_comb begin
		for (int l = 0; l < avg_pkg::LANES; l++) begin
			neg_c[l]  = sq_side[NS].p[l][avg_pkg::P_W-1];
			absp_c[l] = neg_c[l] ? (~sq_side[NS].p[l] + avg_pkg::P_W'(1)) : sq_side[NS].p[l];
			n_c[l]    = ((RW'(absp_c[l][avg_pkg::MAG_W-1:0]) * RW'(arrow_size_q))
				<< (FRACTION_BITS + 1)) + RW'(den_c);
		end
		tail_c.neg   = neg_c;
		tail_c.ex    = sq_side[NS].ex;
		tail_c.ey    = sq_side[NS].ey;
		tail_c.style = sq_side[NS].style;
		tail_c.head  = sq_side[NS].head;
		tail_c.last  = sq_side[NS].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4    <= {den_c, 1'b0};
			n_s4    <= n_c;
			tail_s4 <= tail_c;
		end
	end

	// Divider chain, most significant quotient bit first.
	logic                                  dv_v    [0:QW];
	logic [avg_pkg::DEN_W-1:0]             dv_d    [0:QW];
	logic [avg_pkg::LANES-1:0][RW-1:0]     dv_rem  [0:QW];
	logic [avg_pkg::LANES-1:0][QW-1:0]     dv_q    [0:QW];
	avg_pkg::avg_tail_t                    dv_tail [0:QW];

	assign dv_v[0]    = v_s4;
	assign dv_d[0]    = d_s4;
	assign dv_rem[0]  = n_s4;
	assign dv_q[0]    = '0;
	assign dv_tail[0] = tail_s4;

	for (genvar i = 0; i < QW; i++) begin : g_div
		avg_pkg::avg_ctl_t ctl;
		assign ctl.adv   = adv;
		assign ctl.valid = dv_v[i];
		avg_div_cell #(.FRACTION_BITS(FRACTION_BITS), .BIT_POS(QW - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl),
			.d_in     (dv_d[i]),
			.rem_in   (dv_rem[i]),
			.q_in     (dv_q[i]),
			.tail_in  (dv_tail[i]),
			.v_out    (dv_v[i+1]),
			.d_out    (dv_d[i+1]),
			.rem_out  (dv_rem[i+1]),
			.q_out    (dv_q[i+1]),
			.tail_out (dv_tail[i+1])
		);
	end

	// Output register: vertices are tip minus signed offset.
	avg_pkg::avg_tail_t                            fin;
	logic signed [avg_pkg::WIDE_W-1:0]             tipx_c;
	logic signed [avg_pkg::WIDE_W-1:0]             tipy_c;
	logic [avg_pkg::LANES-1:0][avg_pkg::WIDE_W-1:0] off_c;
	logic [avg_pkg::LANES-1:0][avg_pkg::WIDE_W-1:0] vtx_c;
	logic [avg_pkg::STYLE_W-1:0]                   style_q;
	logic                                          head_q;
	logic [avg_pkg::LANES-1:0][avg_pkg::OUT_W-1:0] vtx_q;
	logic                                          last_q;
	logic                                          tip_match_c;

	assign fin    = dv_tail[QW];
	assign tipx_c = avg_pkg::WIDE_W'($signed(fin.ex)) <<< FRACTION_BITS;
	assign tipy_c = avg_pkg::WIDE_W'($signed(fin.ey)) <<< FRACTION_BITS;

	always_comb begin
		for (int l = 0; l < avg_pkg::LANES; l++) begin
			if (!fin.head) begin
				off_c[l] = '0;
			end else if (fin.neg[l]) begin
				off_c[l] = '0 - avg_pkg::WIDE_W'(dv_q[QW][l]);
			end else begin
				off_c[l] = avg_pkg::WIDE_W'(dv_q[QW][l]);
			end
		end
		vtx_c[avg_pkg::LANE_LX] = tipx_c - off_c[avg_pkg::LANE_LX];
		vtx_c[avg_pkg::LANE_LY] = tipy_c - off_c[avg_pkg::LANE_LY];
		vtx_c[avg_pkg::LANE_RX] = tipx_c - off_c[avg_pkg::LANE_RX];
		vtx_c[avg_pkg::LANE_RY] = tipy_c - off_c[avg_pkg::LANE_RY];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			style_q <= fin.style;
			head_q  <= fin.head;
			last_q  <= fin.last;
			for (int l = 0; l < avg_pkg::LANES; l++) begin
				vtx_q[l] <= vtx_c[l][avg_pkg::OUT_W-1:0];
			end
		end
	end

	assign arrow.valid        = out_valid_q;
	assign arrow.line_style   = style_q;
	assign arrow.head_present = head_q;
	assign arrow.left_x       = vtx_q[avg_pkg::LANE_LX];
	assign arrow.left_y       = vtx_q[avg_pkg::LANE_LY];
	assign arrow.right_x      = vtx_q[avg_pkg::LANE_RX];
	assign arrow.right_y      = vtx_q[avg_pkg::LANE_RY];
	assign arrow.last_arrow   = last_q;

	assign tip_match_c = (vtx_q[avg_pkg::LANE_LX] == vtx_q[avg_pkg::LANE_RX])
		&& (vtx_q[avg_pkg::LANE_LY] == vtx_q[avg_pkg::LANE_RY]);

	`AVG_ASSERT_NOW(a_stall_blocks_in, out_valid_q && !arrow.ready, !seg.ready, "input in stall")
	`AVG_ASSERT_NEXT(a_accept_fills_s1, seg.valid && seg.ready, v_s1, "segment lost at stage 1")
	`AVG_ASSERT_NOW(a_no_head_tip, out_valid_q && !head_q, tip_match_c, "headless vertices differ")
endmodule
